// ===== rtl/plist_pkg.sv =====
// Shared codes, field widths and controller/datapath interface structs
// for the positional list engine. No dependencies.
`timescale 1ns / 1ps

package plist_pkg;

	// beat field widths
	localparam int OP_W   = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	localparam int IN_TDATA_W  = 48;
	localparam int IN_PAD      = IN_TDATA_W - (OP_W + POS_W + VAL_W);
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD     = OUT_TDATA_W - (VAL_W + STAT_W + CNT_W);

	// operation codes
	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
	localparam logic [OP_W-1:0] OP_RM_LAST = 3'd2;
	localparam logic [OP_W-1:0] OP_RM_AT   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture operands, work out target and limits
		logic rd_pos;  // read store at target
		logic rd_nb;   // read neighbor of the shift pointer
		logic mv;      // write read data at pointer, advance pointer
		logic put;     // write element at pointer, count up
		logic cap;     // take read data as result
		logic dec;     // count down
		logic emit;    // load output register
	} plist_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [STAT_W-1:0] stat;
		logic              at_lim;
		logic              near_lim;
	} plist_sts_t;

endpackage

// ===== rtl/plist_ctrl.sv =====
// Controller state machine of the positional list engine.
// Sequences load, read, shift and write steps. Uses plist_pkg.
`timescale 1ns / 1ps

module plist_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [plist_pkg::OP_W-1:0]   opcode,
	output logic                         out_valid,
	input  logic                         out_ready,
	output plist_pkg::plist_cmd_t        cmd,
	input  plist_pkg::plist_sts_t        sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_CAP   = 3'd2;
	localparam logic [2:0] S_MVBEG = 3'd3;
	localparam logic [2:0] S_MV    = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]                    state_q, state_nxt;
	logic [plist_pkg::OP_W-1:0]    op_q;
	logic                          out_valid_q;
	logic                          is_ins, is_rm;

	assign is_ins = (op_q == plist_pkg::OP_APPEND) || (op_q == plist_pkg::OP_INSERT);
	assign is_rm  = (op_q == plist_pkg::OP_RM_LAST) || (op_q == plist_pkg::OP_RM_AT);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.stat != plist_pkg::ST_OK) begin
					state_nxt = S_DONE;
				end else if (is_ins) begin
					state_nxt = S_MVBEG;
				end else if (is_rm || op_q == plist_pkg::OP_READ) begin
					cmd.rd_pos = 1'b1;
					state_nxt  = S_CAP;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_CAP: begin
				cmd.cap = 1'b1;
				if (is_rm) begin
					cmd.dec   = 1'b1;
					state_nxt = S_MVBEG;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_MVBEG: begin
				if (sts.at_lim) begin
					state_nxt = is_ins ? S_PUT : S_DONE;
				end else begin
					cmd.rd_nb = 1'b1;
					state_nxt = S_MV;
				end
			end
			S_MV: begin
				// write the entry read last cycle, fetch the next one
				cmd.mv = 1'b1;
				if (sts.near_lim) begin
					state_nxt = is_ins ? S_PUT : S_DONE;
				end else begin
					cmd.rd_nb = 1'b1;
				end
			end
			S_PUT: begin
				cmd.put   = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
		end
	end

endmodule

// ===== rtl/plist_dp.sv =====
// Datapath of the positional list engine: entry store, count, shift
// pointer, result and output registers. Uses plist_pkg.
`timescale 1ns / 1ps

module plist_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  plist_pkg::plist_cmd_t          cmd,
	output plist_pkg::plist_sts_t          sts,
	input  logic [plist_pkg::OP_W-1:0]     opcode,
	input  logic [plist_pkg::POS_W-1:0]    position,
	input  logic [plist_pkg::VAL_W-1:0]    element_value,
	output logic [plist_pkg::VAL_W-1:0]    result_value,
	output logic [plist_pkg::STAT_W-1:0]   status,
	output logic [plist_pkg::CNT_W-1:0]    item_count
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;
	localparam int CPW  = (DATA_WIDTH < plist_pkg::VAL_W) ? DATA_WIDTH : plist_pkg::VAL_W;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [CW-1:0]         count_q;
	logic [AW-1:0]         tgt_q, idx_q, lim_q;
	logic                  dir_q;     // 1: pointer moves up (remove)
	logic [DATA_WIDTH-1:0] val_q, res_q;
	logic [plist_pkg::STAT_W-1:0] stat_q;

	logic [plist_pkg::VAL_W-1:0]  out_res_q;
	logic [plist_pkg::STAT_W-1:0] out_stat_q;
	logic [plist_pkg::CNT_W-1:0]  out_cnt_q;

	// operand decode at load
	logic [CMPW-1:0] cnt_x, pos_x, cnt_m1, tgt_c, idx_c, lim_c;
	logic            pos_ge, full, empty, dir_c;
	logic [plist_pkg::STAT_W-1:0] stat_c;

	always_comb begin
		cnt_x  = CMPW'(count_q);
		pos_x  = CMPW'(position);
		cnt_m1 = cnt_x - CMPW'(1);
		pos_ge = (pos_x >= cnt_x);
		full   = (count_q == CW'(DEPTH));
		empty  = (count_q == '0);
		tgt_c  = '0;
		idx_c  = '0;
		lim_c  = '0;
		dir_c  = 1'b0;
		stat_c = plist_pkg::ST_OK;
		unique case (opcode)
			plist_pkg::OP_APPEND, plist_pkg::OP_INSERT: begin
				tgt_c  = (opcode == plist_pkg::OP_APPEND || pos_ge) ? cnt_x : pos_x;
				idx_c  = cnt_x;
				lim_c  = tgt_c;
				stat_c = full ? plist_pkg::ST_FULL : plist_pkg::ST_OK;
			end
			plist_pkg::OP_RM_LAST, plist_pkg::OP_RM_AT: begin
				tgt_c  = (opcode == plist_pkg::OP_RM_LAST || pos_ge) ? cnt_m1 : pos_x;
				idx_c  = tgt_c;
				lim_c  = cnt_m1;
				dir_c  = 1'b1;
				stat_c = empty ? plist_pkg::ST_EMPTY : plist_pkg::ST_OK;
			end
			plist_pkg::OP_READ: begin
				tgt_c  = pos_x;
				stat_c = pos_ge ? plist_pkg::ST_RANGE : plist_pkg::ST_OK;
			end
			default: stat_c = plist_pkg::ST_OK;
		endcase
	end

	// shift pointer arithmetic
	logic [AW:0]   idx_e, step1, step2;
	logic [AW-1:0] rd_addr;
	logic          rd_en;

	always_comb begin
		idx_e   = {1'b0, idx_q};
		step1   = dir_q ? idx_e + (AW+1)'(1) : idx_e - (AW+1)'(1);
		step2   = dir_q ? idx_e + (AW+1)'(2) : idx_e - (AW+1)'(2);
		rd_en   = cmd.rd_pos | cmd.rd_nb;
		if (cmd.rd_pos) begin
			rd_addr = tgt_q;
		end else if (cmd.mv) begin
			rd_addr = step2[AW-1:0];
		end else begin
			rd_addr = step1[AW-1:0];
		end
	end

	assign sts.stat     = stat_q;
	assign sts.at_lim   = (idx_q == lim_q);
	assign sts.near_lim = (step1 == {1'b0, lim_q});

	// entry store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.mv) begin
			mem[idx_q] <= rdata_q;
		end else if (cmd.put) begin
			mem[idx_q] <= val_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.put) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q  <= AW'(tgt_c);
			idx_q  <= AW'(idx_c);
			lim_q  <= AW'(lim_c);
			dir_q  <= dir_c;
			val_q  <= DATA_WIDTH'(element_value[CPW-1:0]);
			res_q  <= '0;
			stat_q <= stat_c;
		end else begin
			if (cmd.mv) begin
				idx_q <= step1[AW-1:0];
			end
			if (cmd.cap) begin
				res_q <= rdata_q;
			end
		end
		if (cmd.emit) begin
			out_res_q  <= plist_pkg::VAL_W'(res_q[CPW-1:0]);
			out_stat_q <= stat_q;
			out_cnt_q  <= plist_pkg::CNT_W'(count_q);
		end
	end

	assign result_value = out_res_q;
	assign status       = out_stat_q;
	assign item_count   = out_cnt_q;

endmodule

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: stream ports, controller and
// datapath. Depends on plist_pkg, plist_ctrl and plist_dp.
//
// Usage: each slave beat carries one list operation (append, insert at a
// position, remove last, remove at a position, read at a position); each
// one yields exactly one master beat with the element removed or read, a
// status code and the element count after the operation.
// Sequence: a read goes through execute, capture and done; a rejected
// operation goes from execute straight to done; an insert or a remove
// also moves the entries after the position, at most DEPTH - 1, through
// the entry store, whose single read and single write port move one entry
// per cycle. One operation is in flight at a time; the next beat is taken
// in the cycle after the result is loaded into the output register.
// Reset empties the list at once (the count clears); the store itself is
// not cleared and no clearing pass runs.
// When the receiver stalls, the result waits in the output register while
// the next operation is accepted and worked on; that one then holds until
// the output register is free.
`timescale 1ns / 1ps

module positional_list_engine #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// opcode[2:0], position[10:3], element_value[42:11], zero pad
	input  logic [plist_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_value[31:0], status[33:32], item_count[38:34], zero pad
	output logic [plist_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int P_LO = plist_pkg::OP_W;
	localparam int V_LO = plist_pkg::OP_W + plist_pkg::POS_W;

	plist_pkg::plist_cmd_t cmd;
	plist_pkg::plist_sts_t sts;

	logic [plist_pkg::OP_W-1:0]   opcode;
	logic [plist_pkg::POS_W-1:0]  position;
	logic [plist_pkg::VAL_W-1:0]  element_value;
	logic [plist_pkg::VAL_W-1:0]  result_value;
	logic [plist_pkg::STAT_W-1:0] status;
	logic [plist_pkg::CNT_W-1:0]  item_count;

	assign opcode        = s_tdata[P_LO-1:0];
	assign position      = s_tdata[V_LO-1:P_LO];
	assign element_value = s_tdata[V_LO+plist_pkg::VAL_W-1:V_LO];

	assign m_tdata = {{plist_pkg::OUT_PAD{1'b0}}, item_count, status, result_value};

	plist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.opcode    (opcode),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	plist_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.position      (position),
		.element_value (element_value),
		.result_value  (result_value),
		.status        (status),
		.item_count    (item_count)
	);

	localparam logic [plist_pkg::CNT_W-1:0] FULL_CNT = plist_pkg::CNT_W'(DEPTH);

	// an accepted beat never produces its result on the next edge
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after accept");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == plist_pkg::ST_FULL |-> item_count == FULL_CNT)
		else $error("full status with count below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == plist_pkg::ST_EMPTY |-> item_count == '0)
		else $error("empty status with nonzero count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status != plist_pkg::ST_OK |-> result_value == '0)
		else $error("nonzero element with error status");

endmodule

// ===== tb/sv/positional_list_engine_test.sv =====
// Self-checking testbench for positional_list_engine: drives random list operations over the
// stream ports and checks every result beat against an in-bench list model.
// Depends on plist_pkg and the positional_list_engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_test;
	import plist_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_OPS = 850;
	localparam int STEADY_OPS = 70;
	localparam int BACKLOG_AT = 300;
	localparam int DRAIN_AT = 500;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	class list_scoreboard;
		logic [VAL_W-1:0] entries[LIST_DEPTH];
		int               held;
		list_result_t     due_results[$];
		int               errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		// apply one accepted operation to the list and queue its result
		function void record_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			list_result_t r;
			int at;
			int i;
			r.value = '0;
			r.status = ST_OK;
			case (op)
				OP_APPEND, OP_INSERT: begin
					if (held >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						at = (op == OP_APPEND || int'(pos) > held) ? held : int'(pos);
						for (i = held; i > at; i--)
							entries[i] = entries[i - 1];
						entries[at] = val;
						held++;
					end
				end
				OP_RM_LAST, OP_RM_AT: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						at = (op == OP_RM_LAST || int'(pos) >= held) ? held - 1 : int'(pos);
						r.value = entries[at];
						for (i = at; i + 1 < held; i++)
							entries[i] = entries[i + 1];
						held--;
					end
				end
				OP_READ: begin
					if (int'(pos) >= held)
						r.status = ST_RANGE;
					else
						r.value = entries[pos];
				end
				default: begin
				end
			endcase
			r.count = held[CNT_W-1:0];
			due_results.push_back(r);
		endfunction

		function void check_result_beat(logic [OUT_TDATA_W-1:0] beat);
			list_result_t exp_r;
			if (due_results.size() == 0) begin
				$error("result beat %h arrived with no operation outstanding", beat);
				errors++;
				return;
			end
			exp_r = due_results.pop_front();
			if (beat[31:0] !== exp_r.value) begin
				$error("result_value mismatch: expected %h, got %h", exp_r.value, beat[31:0]);
				errors++;
			end
			if (beat[33:32] !== exp_r.status) begin
				$error("status mismatch: expected %0d, got %0d", exp_r.status, beat[33:32]);
				errors++;
			end
			if (beat[38:34] !== exp_r.count) begin
				$error("item_count mismatch: expected %0d, got %0d", exp_r.count, beat[38:34]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	list_scoreboard sb;
	bit             steady;
	bit             hold_request;
	int             quiet_cycles;

	positional_list_engine #(
		.DEPTH(LIST_DEPTH),
		.DATA_WIDTH(VAL_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sample both handshakes on the edge; check the result before noting the new op
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result_beat(m_tdata);
			if (s_tvalid && s_tready)
				sb.record_list_op(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = int'($urandom_range(1, 9)) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		s_tvalid <= 1'b1;
		s_tdata <= {{IN_PAD{1'b0}}, val, pos, op};
		do @(posedge clk); while (!s_tready);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic send_random_op(input bit grow);
		int               roll;
		int               held;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		held = sb.held;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else if (roll < 20)
			op = OP_READ;
		else if (roll < (grow ? 75 : 45))
			op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
		else
			op = $urandom_range(0, 1) ? OP_RM_LAST : OP_RM_AT;
		if ($urandom_range(0, 4) == 0)
			pos = POS_W'($urandom_range(0, 255));
		else
			pos = POS_W'($urandom_range(0, held));
		roll = $urandom_range(0, 19);
		if (roll == 0)
			val = '0;
		else if (roll == 1)
			val = '1;
		else
			val = $urandom;
		send_op(op, pos, val);
	endtask

	initial begin
		int n;
		sb = new();
		steady = 1'b0;
		hold_request = 1'b0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_op(OP_READ, 8'd0, 32'h0);
		send_op(OP_RM_LAST, 8'd0, 32'h0);
		send_op(OP_RM_AT, 8'd255, 32'h0);
		send_op(OP_SPARE_LO, 8'd0, 32'hFFFF_FFFF);
		// insert at the front, append, insert past the end, insert in the middle
		send_op(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
		send_op(OP_APPEND, 8'd255, 32'h0);
		send_op(OP_INSERT, 8'd255, 32'hA5A5_A5A5);
		send_op(OP_INSERT, 8'd1, 32'h5A5A_5A5A);
		send_op(OP_READ, 8'd3, 32'h0);
		send_op(OP_READ, 8'd4, 32'h0);
		// remove past the end takes the last element
		send_op(OP_RM_AT, 8'd255, 32'h0);
		// fill up, then hit the full case
		for (n = 0; n < LIST_DEPTH - 3; n++)
			send_op(OP_INSERT, POS_W'($urandom_range(0, 3 + n)), $urandom);
		send_op(OP_APPEND, 8'd0, 32'h1234_5678);
		send_op(OP_INSERT, 8'd0, 32'h8765_4321);
		send_op(OP_READ, 8'd15, 32'h0);

		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS - STEADY_OPS)
				steady = 1'b1;
			if (n == BACKLOG_AT)
				hold_request = 1'b1;
			if (n == DRAIN_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.due_results.size() != 0) @(posedge clk);
			end
			send_random_op((n / 40) % 2 == 0);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/plist_pkg.sv
rtl/plist_ctrl.sv
rtl/plist_dp.sv
rtl/positional_list_engine.sv
tb/sv/positional_list_engine_test.sv
